// ----- hdl/slfd_pkg.sv -----
// Package for the sorted line directory: sizes, derived widths, codes and the
// structs that travel between the front, back and result queue.
// No dependencies.
package slfd_pkg;

    localparam int MAX_LINES   = 256;
    localparam int STORE_BYTES = 4096;
    localparam int STAGE_BYTES = 256;

    localparam int EAW = $clog2(MAX_LINES);
    localparam int LCW = $clog2(MAX_LINES + 1);
    localparam int BAW = $clog2(STORE_BYTES);
    localparam int SZW = $clog2(STORE_BYTES + 1);
    localparam int SAW = $clog2(STAGE_BYTES);
    localparam int SCW = $clog2(STAGE_BYTES + 1);

    typedef enum logic [2:0] {
        OP_SEARCH   = 3'd0,
        OP_INSERT   = 3'd1,
        OP_DELETE   = 3'd2,
        OP_RD_ENTRY = 3'd3,
        OP_RD_BYTE  = 3'd4
    } op_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_TOO_MANY  = 2'd2,
        ST_SIZE_OVER = 2'd3
    } status_t;

    typedef struct packed {
        logic [2:0]  op;
        logic [14:0] ln;
        logic [14:0] eln;
        logic [7:0]  db;
        logic        last;
        logic [8:0]  ei;
        logic [11:0] ba;
    } cmd_t;

    typedef struct packed {
        status_t     status;
        logic        found;
        logic [8:0]  fidx;
        logic [14:0] eline;
        logic [11:0] eaddr;
        logic [8:0]  elen;
        logic [7:0]  dout;
        logic [8:0]  lcount;
        logic [12:0] psize;
    } res_t;

    typedef struct packed {
        logic [14:0]    num;
        logic [BAW-1:0] addr;
        logic [SCW-1:0] len;
    } ent_t;

endpackage

// ----- hdl/slfd_front.sv -----
// Front of the sorted line directory: takes command beats, drops unknown
// operations and holds the rest in a two-deep queue for the back.
// Depends on slfd_pkg.
module slfd_front
    import slfd_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    output logic full,
    input  cmd_t in_cmd,
    output logic cmd_valid,
    output cmd_t cmd_out,
    input  logic cmd_pop
);

    cmd_t       q_reg [2];
    logic       rd_ptr_reg, rd_ptr_next;
    logic       wr_ptr_reg, wr_ptr_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       known;
    logic       keep;
    logic       take;

    always_comb
    begin
        unique case (in_cmd.op)
            OP_SEARCH, OP_INSERT, OP_DELETE, OP_RD_ENTRY, OP_RD_BYTE: known = 1'b1;
            default: known = 1'b0;
        endcase
    end

    assign full      = (cnt_reg == 2'd2);
    assign cmd_valid = (cnt_reg != 2'd0);
    assign cmd_out   = q_reg[rd_ptr_reg];
    // drop beats with an operation that means nothing
    assign keep      = push && !full && known;
    assign take      = cmd_pop && cmd_valid;

    always_comb
    begin
        wr_ptr_next = keep ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = take ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + {1'b0, keep} - {1'b0, take};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg <= 1'b0;
            wr_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            rd_ptr_reg <= rd_ptr_next;
            wr_ptr_reg <= wr_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (keep)
        begin
            q_reg[wr_ptr_reg] <= in_cmd;
        end
    end

endmodule

// ----- hdl/slfd_rq.sv -----
// Result queue of the sorted line directory: two-deep queue between the back
// and the result ports.
// Depends on slfd_pkg.
module slfd_rq
    import slfd_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic res_push,
    input  res_t res_in,
    output logic res_full,
    input  logic pop,
    output logic empty,
    output res_t res_out
);

    res_t       q_reg [2];
    logic       rd_ptr_reg;
    logic       wr_ptr_reg;
    logic [1:0] cnt_reg;
    logic       put;
    logic       take;

    assign res_full = (cnt_reg == 2'd2);
    assign empty    = (cnt_reg == 2'd0);
    assign res_out  = q_reg[rd_ptr_reg];
    assign put      = res_push && !res_full;
    assign take     = pop && !empty;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg <= 1'b0;
            wr_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (put)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (take)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            cnt_reg <= cnt_reg + {1'b0, put} - {1'b0, take};
        end
    end

    always_ff @(posedge clk)
    begin
        if (put)
        begin
            q_reg[wr_ptr_reg] <= res_in;
        end
    end

endmodule

// ----- hdl/slfd_back.sv -----
// Back of the sorted line directory: sequencer that owns the directory, byte
// store and staging memories and carries out one command at a time.
// Depends on slfd_pkg.
module slfd_back
    import slfd_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic cmd_valid,
    input  cmd_t cmd,
    output logic cmd_pop,
    output logic res_push,
    output res_t res,
    input  logic res_full
);

    typedef enum logic [16:0] {
        S_IDLE     = 17'h00001,
        S_LOC_RD   = 17'h00002,
        S_LOC_CMP  = 17'h00004,
        S_AFTER    = 17'h00008,
        S_NEXT_RD  = 17'h00010,
        S_NEXT_CMP = 17'h00020,
        S_DEL_GO   = 17'h00040,
        S_DMV_B    = 17'h00080,
        S_DMV_E    = 17'h00100,
        S_DEL_FIN  = 17'h00200,
        S_INS_GO   = 17'h00400,
        S_IMV_B    = 17'h00800,
        S_IMV_E    = 17'h01000,
        S_ICP      = 17'h02000,
        S_ENT_WR   = 17'h04000,
        S_RD_WAIT  = 17'h08000,
        S_RESULT   = 17'h10000
    } state_t;

    typedef enum logic [2:0] {
        R_SEARCH,
        R_DEL1,
        R_DEL2,
        R_INS1,
        R_INS2
    } ret_t;

    // memories
    ent_t        ent_mem  [MAX_LINES];
    logic [7:0]  byte_mem [STORE_BYTES];
    logic [7:0]  stg_mem  [STAGE_BYTES];
    ent_t        ent_rd_reg;
    logic [7:0]  byte_rd_reg;
    logic [7:0]  stg_rd_reg;

    logic [EAW-1:0] ent_raddr, ent_waddr;
    logic           ent_we;
    ent_t           ent_wdata;
    logic [BAW-1:0] byte_raddr, byte_waddr;
    logic           byte_we;
    logic [7:0]     byte_wdata;
    logic [SAW-1:0] stg_raddr, stg_waddr;
    logic           stg_we;
    logic [7:0]     stg_wdata;

    // control state
    state_t         state_reg, state_next;
    logic [LCW-1:0] stored_reg, stored_next;
    logic [SZW-1:0] used_reg, used_next;
    logic [SCW-1:0] staged_reg, staged_next;
    logic           ovf_reg, ovf_next;
    logic [SZW-1:0] mv_cnt_reg, mv_cnt_next;
    logic           wr_pend_reg, wr_pend_next;

    // working payload
    cmd_t           c_reg, c_next;
    res_t           res_reg, res_next;
    ret_t           ret_reg, ret_next;
    logic [14:0]    tgt_reg, tgt_next;
    logic [LCW-1:0] i_reg, i_next;
    logic           hit_reg, hit_next;
    logic [LCW-1:0] idx_reg, idx_next;
    logic [SZW-1:0] laddr_reg, laddr_next;
    logic [LCW-1:0] s_reg, s_next;
    logic [LCW-1:0] e_reg, e_next;
    logic [SZW-1:0] base_reg, base_next;
    logic [SZW-1:0] top_reg, top_next;
    logic [SCW-1:0] len_reg, len_next;
    logic           commit_reg, commit_next;
    logic [SZW-1:0] start_reg, start_next;
    logic [SZW-1:0] mv_src_reg, mv_src_next;
    logic [SZW-1:0] mv_dst_reg, mv_dst_next;
    logic           mv_up_reg, mv_up_next;
    logic [SZW-1:0] wr_addr_reg, wr_addr_next;

    logic           mv_done;
    logic [SZW-1:0] mv_src_adv, mv_dst_adv;
    logic [SZW-1:0] dbytes;
    logic [LCW-1:0] i_m1, idx_m1;
    logic [31:0]    ei_m1;
    logic [31:0]    ba_ext;
    logic [SCW-1:0] staged_inc;
    logic           ovf_inc;
    logic [SZW:0]   size_sum;

    assign mv_done    = (mv_cnt_reg == '0) && !wr_pend_reg;
    assign mv_src_adv = mv_up_reg ? mv_src_reg + SZW'(1) : mv_src_reg - SZW'(1);
    assign mv_dst_adv = mv_up_reg ? mv_dst_reg + SZW'(1) : mv_dst_reg - SZW'(1);
    assign dbytes     = top_reg - base_reg;
    assign i_m1       = i_reg - LCW'(1);
    assign idx_m1     = idx_reg - LCW'(1);
    assign ei_m1      = 32'(cmd.ei) - 32'd1;
    assign ba_ext     = 32'(cmd.ba);
    assign res        = res_next;

    always_comb
    begin
        if (staged_reg < SCW'(STAGE_BYTES))
        begin
            staged_inc = staged_reg + SCW'(1);
            ovf_inc    = ovf_reg;
        end
        else
        begin
            staged_inc = staged_reg;
            ovf_inc    = 1'b1;
        end
        size_sum = (SZW+1)'(used_reg) + (SZW+1)'(staged_inc);
    end

    always_comb
    begin
        state_next   = state_reg;
        stored_next  = stored_reg;
        used_next    = used_reg;
        staged_next  = staged_reg;
        ovf_next     = ovf_reg;
        mv_cnt_next  = mv_cnt_reg;
        wr_pend_next = 1'b0;
        c_next       = c_reg;
        res_next     = res_reg;
        ret_next     = ret_reg;
        tgt_next     = tgt_reg;
        i_next       = i_reg;
        hit_next     = hit_reg;
        idx_next     = idx_reg;
        laddr_next   = laddr_reg;
        s_next       = s_reg;
        e_next       = e_reg;
        base_next    = base_reg;
        top_next     = top_reg;
        len_next     = len_reg;
        commit_next  = commit_reg;
        start_next   = start_reg;
        mv_src_next  = mv_src_reg;
        mv_dst_next  = mv_dst_reg;
        mv_up_next   = mv_up_reg;
        wr_addr_next = wr_addr_reg;

        ent_raddr  = mv_src_reg[EAW-1:0];
        ent_we     = 1'b0;
        ent_waddr  = wr_addr_reg[EAW-1:0];
        ent_wdata  = ent_rd_reg;
        byte_raddr = mv_src_reg[BAW-1:0];
        byte_we    = 1'b0;
        byte_waddr = wr_addr_reg[BAW-1:0];
        byte_wdata = byte_rd_reg;
        stg_raddr  = mv_src_reg[SAW-1:0];
        stg_we     = 1'b0;
        stg_waddr  = staged_reg[SAW-1:0];
        stg_wdata  = cmd.db;

        cmd_pop  = 1'b0;
        res_push = 1'b0;

        // shared move engine: read at the source, write in the next cycle
        if ((state_reg == S_DMV_B) || (state_reg == S_DMV_E) || (state_reg == S_IMV_B) ||
            (state_reg == S_IMV_E) || (state_reg == S_ICP))
        begin
            if (mv_cnt_reg != '0)
            begin
                mv_src_next  = mv_src_adv;
                mv_dst_next  = mv_dst_adv;
                mv_cnt_next  = mv_cnt_reg - SZW'(1);
                wr_pend_next = 1'b1;
                wr_addr_next = mv_dst_reg;
            end
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_pop     = 1'b1;
                    c_next      = cmd;
                    res_next    = '0;
                    i_next      = LCW'(1);
                    tgt_next    = cmd.ln;
                    commit_next = 1'b0;
                    unique case (cmd.op)
                        OP_SEARCH:
                        begin
                            ret_next   = R_SEARCH;
                            state_next = S_LOC_RD;
                        end
                        OP_INSERT:
                        begin
                            stg_we      = (staged_reg < SCW'(STAGE_BYTES));
                            staged_next = staged_inc;
                            ovf_next    = ovf_inc;
                            if (cmd.last)
                            begin
                                // capture the length and clear the staging
                                len_next    = staged_inc;
                                staged_next = '0;
                                ovf_next    = 1'b0;
                                if (stored_reg >= LCW'(MAX_LINES))
                                begin
                                    res_next.status = ST_TOO_MANY;
                                    state_next      = S_RESULT;
                                end
                                else if (ovf_inc || (size_sum > (SZW+1)'(STORE_BYTES)))
                                begin
                                    res_next.status = ST_SIZE_OVER;
                                    state_next      = S_RESULT;
                                end
                                else
                                begin
                                    commit_next = 1'b1;
                                    ret_next    = R_INS1;
                                    state_next  = S_LOC_RD;
                                end
                            end
                        end
                        OP_DELETE:
                        begin
                            if (stored_reg == '0)
                            begin
                                res_next.status = ST_NOT_FOUND;
                                state_next      = S_RESULT;
                            end
                            else
                            begin
                                ret_next   = R_DEL1;
                                state_next = S_LOC_RD;
                            end
                        end
                        OP_RD_ENTRY:
                        begin
                            ent_raddr = ei_m1[EAW-1:0];
                            if ((cmd.ei != '0) && (32'(cmd.ei) <= 32'(stored_reg)))
                            begin
                                state_next = S_RD_WAIT;
                            end
                            else
                            begin
                                res_next.status = ST_NOT_FOUND;
                                state_next      = S_RESULT;
                            end
                        end
                        OP_RD_BYTE:
                        begin
                            byte_raddr = ba_ext[BAW-1:0];
                            if (ba_ext < 32'(used_reg))
                            begin
                                state_next = S_RD_WAIT;
                            end
                            else
                            begin
                                res_next.status = ST_NOT_FOUND;
                                state_next      = S_RESULT;
                            end
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_LOC_RD:
            begin
                ent_raddr = i_m1[EAW-1:0];
                if (i_reg > stored_reg)
                begin
                    hit_next   = 1'b0;
                    idx_next   = stored_reg + LCW'(1);
                    laddr_next = used_reg;
                    state_next = S_AFTER;
                end
                else
                begin
                    state_next = S_LOC_CMP;
                end
            end
            S_LOC_CMP:
            begin
                if (ent_rd_reg.num >= tgt_reg)
                begin
                    hit_next   = (ent_rd_reg.num == tgt_reg);
                    idx_next   = i_reg;
                    laddr_next = SZW'(ent_rd_reg.addr);
                    state_next = S_AFTER;
                end
                else
                begin
                    i_next     = i_reg + LCW'(1);
                    state_next = S_LOC_RD;
                end
            end
            S_AFTER:
            begin
                i_next = LCW'(1);
                unique case (ret_reg)
                    R_SEARCH:
                    begin
                        res_next.found  = hit_reg;
                        res_next.fidx   = 9'(idx_reg);
                        res_next.status = hit_reg ? ST_OK : ST_NOT_FOUND;
                        state_next      = S_RESULT;
                    end
                    R_DEL1:
                    begin
                        if (!hit_reg)
                        begin
                            res_next.status = ST_NOT_FOUND;
                            state_next      = S_RESULT;
                        end
                        else
                        begin
                            s_next     = idx_reg;
                            base_next  = laddr_reg;
                            tgt_next   = c_reg.eln;
                            ret_next   = R_DEL2;
                            state_next = S_LOC_RD;
                        end
                    end
                    R_DEL2:
                    begin
                        if (!hit_reg || (idx_reg < s_reg))
                        begin
                            res_next.status = ST_NOT_FOUND;
                            state_next      = S_RESULT;
                        end
                        else
                        begin
                            e_next     = idx_reg;
                            state_next = S_NEXT_RD;
                        end
                    end
                    R_INS1:
                    begin
                        if (hit_reg)
                        begin
                            // replace: drop the old line first
                            s_next     = idx_reg;
                            e_next     = idx_reg;
                            base_next  = laddr_reg;
                            state_next = S_NEXT_RD;
                        end
                        else
                        begin
                            start_next = laddr_reg;
                            state_next = S_INS_GO;
                        end
                    end
                    R_INS2:
                    begin
                        start_next = laddr_reg;
                        state_next = S_INS_GO;
                    end
                    default:
                    begin
                        state_next = S_IDLE;
                    end
                endcase
            end
            S_NEXT_RD:
            begin
                ent_raddr = e_reg[EAW-1:0];
                if (e_reg < stored_reg)
                begin
                    state_next = S_NEXT_CMP;
                end
                else
                begin
                    top_next   = used_reg;
                    state_next = S_DEL_GO;
                end
            end
            S_NEXT_CMP:
            begin
                top_next   = SZW'(ent_rd_reg.addr);
                state_next = S_DEL_GO;
            end
            S_DEL_GO:
            begin
                mv_src_next = top_reg;
                mv_dst_next = base_reg;
                mv_cnt_next = used_reg - top_reg;
                mv_up_next  = 1'b1;
                state_next  = S_DMV_B;
            end
            S_DMV_B:
            begin
                byte_we = wr_pend_reg;
                if (mv_done)
                begin
                    mv_src_next = SZW'(e_reg);
                    mv_dst_next = SZW'(s_reg) - SZW'(1);
                    mv_cnt_next = SZW'(stored_reg) - SZW'(e_reg);
                    mv_up_next  = 1'b1;
                    state_next  = S_DMV_E;
                end
            end
            S_DMV_E:
            begin
                ent_we         = wr_pend_reg;
                ent_wdata.addr = BAW'(SZW'(ent_rd_reg.addr) - dbytes);
                if (mv_done)
                begin
                    state_next = S_DEL_FIN;
                end
            end
            S_DEL_FIN:
            begin
                used_next   = used_reg - dbytes;
                stored_next = stored_reg - (e_reg - s_reg + LCW'(1));
                if (commit_reg)
                begin
                    i_next     = LCW'(1);
                    tgt_next   = c_reg.ln;
                    ret_next   = R_INS2;
                    state_next = S_LOC_RD;
                end
                else
                begin
                    res_next.status = ST_OK;
                    state_next      = S_RESULT;
                end
            end
            S_INS_GO:
            begin
                mv_src_next = used_reg - SZW'(1);
                mv_dst_next = used_reg - SZW'(1) + SZW'(len_reg);
                mv_cnt_next = used_reg - start_reg;
                mv_up_next  = 1'b0;
                state_next  = S_IMV_B;
            end
            S_IMV_B:
            begin
                byte_we = wr_pend_reg;
                if (mv_done)
                begin
                    mv_src_next = SZW'(stored_reg) - SZW'(1);
                    mv_dst_next = SZW'(stored_reg);
                    mv_cnt_next = SZW'(stored_reg) - SZW'(idx_reg) + SZW'(1);
                    mv_up_next  = 1'b0;
                    state_next  = S_IMV_E;
                end
            end
            S_IMV_E:
            begin
                ent_we         = wr_pend_reg;
                ent_wdata.addr = BAW'(SZW'(ent_rd_reg.addr) + SZW'(len_reg));
                if (mv_done)
                begin
                    mv_src_next = '0;
                    mv_dst_next = start_reg;
                    mv_cnt_next = SZW'(len_reg);
                    mv_up_next  = 1'b1;
                    state_next  = S_ICP;
                end
            end
            S_ICP:
            begin
                byte_we    = wr_pend_reg;
                byte_wdata = stg_rd_reg;
                if (mv_done)
                begin
                    state_next = S_ENT_WR;
                end
            end
            S_ENT_WR:
            begin
                ent_we          = 1'b1;
                ent_waddr       = idx_m1[EAW-1:0];
                ent_wdata.num   = c_reg.ln;
                ent_wdata.addr  = start_reg[BAW-1:0];
                ent_wdata.len   = len_reg;
                used_next       = used_reg + SZW'(len_reg);
                stored_next     = stored_reg + LCW'(1);
                res_next.status = ST_OK;
                state_next      = S_RESULT;
            end
            S_RD_WAIT:
            begin
                res_next.status = ST_OK;
                if (c_reg.op == OP_RD_ENTRY)
                begin
                    res_next.eline = ent_rd_reg.num;
                    res_next.eaddr = 12'(ent_rd_reg.addr);
                    res_next.elen  = 9'(ent_rd_reg.len);
                end
                else
                begin
                    res_next.dout = byte_rd_reg;
                end
                state_next = S_RESULT;
            end
            S_RESULT:
            begin
                res_next.lcount = 9'(stored_reg);
                res_next.psize  = 13'(used_reg);
                if (!res_full)
                begin
                    res_push   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // the pushed beat carries the counts as they stand after the command
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            stored_reg  <= '0;
            used_reg    <= '0;
            staged_reg  <= '0;
            ovf_reg     <= 1'b0;
            mv_cnt_reg  <= '0;
            wr_pend_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            stored_reg  <= stored_next;
            used_reg    <= used_next;
            staged_reg  <= staged_next;
            ovf_reg     <= ovf_next;
            mv_cnt_reg  <= mv_cnt_next;
            wr_pend_reg <= wr_pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        c_reg       <= c_next;
        res_reg     <= res_next;
        ret_reg     <= ret_next;
        tgt_reg     <= tgt_next;
        i_reg       <= i_next;
        hit_reg     <= hit_next;
        idx_reg     <= idx_next;
        laddr_reg   <= laddr_next;
        s_reg       <= s_next;
        e_reg       <= e_next;
        base_reg    <= base_next;
        top_reg     <= top_next;
        len_reg     <= len_next;
        commit_reg  <= commit_next;
        start_reg   <= start_next;
        mv_src_reg  <= mv_src_next;
        mv_dst_reg  <= mv_dst_next;
        mv_up_reg   <= mv_up_next;
        wr_addr_reg <= wr_addr_next;
    end

    always_ff @(posedge clk)
    begin
        if (ent_we)
        begin
            ent_mem[ent_waddr] <= ent_wdata;
        end
        ent_rd_reg <= ent_mem[ent_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (byte_we)
        begin
            byte_mem[byte_waddr] <= byte_wdata;
        end
        byte_rd_reg <= byte_mem[byte_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (stg_we)
        begin
            stg_mem[stg_waddr] <= stg_wdata;
        end
        stg_rd_reg <= stg_mem[stg_raddr];
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        used_reg <= SZW'(STORE_BYTES))
        else $error("byte store overfilled");

    assert property (@(posedge clk) disable iff (!rst_n)
        stored_reg <= LCW'(MAX_LINES))
        else $error("directory overfilled");

    assert property (@(posedge clk) disable iff (!rst_n)
        staged_reg <= SCW'(STAGE_BYTES))
        else $error("staging overfilled");

    assert property (@(posedge clk) disable iff (!rst_n)
        wr_pend_reg |-> $past(mv_cnt_reg != '0))
        else $error("move write without a read");

    assert property (@(posedge clk) disable iff (!rst_n)
        cmd_pop |-> !wr_pend_reg && (mv_cnt_reg == '0))
        else $error("new command taken while a move is in flight");

endmodule

// ----- hdl/sorted_line_directory.sv -----
// Sorted line directory top level: front queue, back sequencer and result
// queue wired to the ports. Depends on slfd_pkg, slfd_front, slfd_back and slfd_rq.
//
// Operation: a search scans the entries in order; insert and delete move one byte
//   and one entry per cycle through memories with one read and one write port; a
//   replacing insert scans twice and moves the bytes above it down and back up.
// Throughput: one command in the back at a time; two more may wait in the front.
// Reset: asynchronous, clears counts, staging and queues; memories are not cleared.
module sorted_line_directory
    import slfd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [2:0]  operation,
    input  logic [14:0] line_number,
    input  logic [14:0] end_line_number,
    input  logic [7:0]  data_byte,
    input  logic        last_byte,
    input  logic [8:0]  entry_index,
    input  logic [11:0] byte_address,
    output logic        empty,
    input  logic        pop,
    output logic [1:0]  status,
    output logic        found,
    output logic [8:0]  found_index,
    output logic [14:0] entry_line,
    output logic [11:0] entry_address,
    output logic [8:0]  entry_length,
    output logic [7:0]  data_out,
    output logic [8:0]  line_count,
    output logic [12:0] program_size
);

    cmd_t in_cmd;
    cmd_t cmd;
    logic cmd_valid;
    logic cmd_pop;
    res_t res_b;
    logic res_push;
    logic res_full;
    res_t res_out;

    // gather the command beat into one struct
    assign in_cmd.op   = operation;
    assign in_cmd.ln   = line_number;
    assign in_cmd.eln  = end_line_number;
    assign in_cmd.db   = data_byte;
    assign in_cmd.last = last_byte;
    assign in_cmd.ei   = entry_index;
    assign in_cmd.ba   = byte_address;

    // front: accept beats, drop unknown operations, hold a short queue
    slfd_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .in_cmd    (in_cmd),
        .cmd_valid (cmd_valid),
        .cmd_out   (cmd),
        .cmd_pop   (cmd_pop)
    );

    // back: search, insert, delete and reads over the memories
    slfd_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop),
        .res_push  (res_push),
        .res       (res_b),
        .res_full  (res_full)
    );

    // result queue: hold finished beats until popped
    slfd_rq u_rq
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .res_push (res_push),
        .res_in   (res_b),
        .res_full (res_full),
        .pop      (pop),
        .empty    (empty),
        .res_out  (res_out)
    );

    assign status        = res_out.status;
    assign found         = res_out.found;
    assign found_index   = res_out.fidx;
    assign entry_line    = res_out.eline;
    assign entry_address = res_out.eaddr;
    assign entry_length  = res_out.elen;
    assign data_out      = res_out.dout;
    assign line_count    = res_out.lcount;
    assign program_size  = res_out.psize;

endmodule
